[rtl/hskw_pkg.sv]
`timescale 1ns / 1ps

package hskw_pkg;

	// Number of entries in the seed/key table (valid range 2 to 16).
	localparam int unsigned TABLE_ENTRIES = 8;
	localparam int unsigned IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		KIND_TICK      = 2'd0,
		KIND_KEY       = 2'd1,
		KIND_HANDSHAKE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		LINK_NONE = 2'd0,
		LINK_SYNC = 2'd1,
		LINK_EST  = 2'd2
	} link_phase_t;

	typedef enum logic [1:0] {
		ST_NORMAL  = 2'd0,
		ST_KEY_ERR = 2'd1,
		ST_TIMEOUT = 2'd2,
		ST_LATCHED = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_BYTE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED_PERIOD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_WINDOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ERR_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 3'd5;

	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [7:0]  ack_byte;
		logic [15:0] seed_period_ticks;
		logic [15:0] key_window_ticks;
		logic [7:0]  key_error_limit;
		logic [7:0]  timeout_limit;
	} cfg_t;

	typedef struct packed {
		link_phase_t link_state;
		status_t     error_status;
		logic        reply_valid;
		logic        seed_valid;
		logic [7:0]  seed_value;
		logic [7:0]  key_error_total;
		logic [7:0]  timeout_total;
		logic [15:0] seeds_sent;
		logic [15:0] keys_received;
	} res_t;

	// Expected key for a table entry; entries from index 8 upward repeat the first eight keys.
	function automatic logic [7:0] key_of(idx_t idx);
		logic [2:0] low;
		logic [7:0] key;
		low = 3'(idx);
		case (low)
			3'd0:    key = 8'd27;
			3'd1:    key = 8'd31;
			3'd2:    key = 8'd13;
			3'd3:    key = 8'd9;
			3'd4:    key = 8'd12;
			3'd5:    key = 8'd6;
			3'd6:    key = 8'd71;
			default: key = 8'd44;
		endcase
		return key;
	endfunction

	// Run counter increment that stops at the limit.
	function automatic logic [7:0] sat_run(logic [7:0] run, logic [7:0] limit);
		logic [7:0] n;
		n = run + 8'd1;
		if (run == 8'hFF || n >= limit)
			n = limit;
		return n;
	endfunction

endpackage

[rtl/handshake_and_seed_key_watchdog.sv]
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
// evt       evt_valid/evt_ready   kind, data
// res       res_valid/res_ready   link_state, error_status, reply_valid, seed_valid,
//                                 seed_value, key_error_total, timeout_total,
//                                 seeds_sent, keys_received
//
// Every event transaction yields exactly one result transaction via the input and
// result registers; one event per cycle is sustained while results are not stalled.
// The rate is set by the single registered pass through the watchdog state update.
// arst_n clears the link, counters and status and restores the register defaults.
// A stalled result holds in its register while one further event waits in the input
// register; beyond that evt_ready drops. cfg_ready is always high.

module handshake_and_seed_key_watchdog import hskw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  evt_valid,
	output logic                  evt_ready,
	input  logic [1:0]            kind,
	input  logic [7:0]            data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [1:0]            link_state,
	output logic [1:0]            error_status,
	output logic                  reply_valid,
	output logic                  seed_valid,
	output logic [7:0]            seed_value,
	output logic [7:0]            key_error_total,
	output logic [7:0]            timeout_total,
	output logic [15:0]           seeds_sent,
	output logic [15:0]           keys_received
);

	cfg_t       cfg;
	res_t       res_next;

	// Input stage: the accepted event waits here until the result register can take it.
	logic       evt_valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] data_s1;

	// Result stage.
	logic       res_valid_s2;
	res_t       res_s2;

	logic       advance;

	assign advance   = evt_valid_s1 && (!res_valid_s2 || res_ready);
	assign evt_ready = !evt_valid_s1 || advance;

	hskw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The watchdog state commits only when its result moves into the result stage.
	hskw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.kind   (kind_s1),
		.data   (data_s1),
		.cfg    (cfg),
		.res    (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			evt_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			kind_s1 <= kind;
			data_s1 <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid       = res_valid_s2;
	assign link_state      = res_s2.link_state;
	assign error_status    = res_s2.error_status;
	assign reply_valid     = res_s2.reply_valid;
	assign seed_valid      = res_s2.seed_valid;
	assign seed_value      = res_s2.seed_value;
	assign key_error_total = res_s2.key_error_total;
	assign timeout_total   = res_s2.timeout_total;
	assign seeds_sent      = res_s2.seeds_sent;
	assign keys_received   = res_s2.keys_received;

	// Once the error has latched, no later result may report anything else.
	a_latched_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && error_status == ST_LATCHED |=> error_status == ST_LATCHED)
		else $error("latched error status was cleared");

	// Seeds are only issued on an established link.
	a_seed_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seed_valid |-> link_state == LINK_EST)
		else $error("seed issued outside the established phase");

	// A handshake reply always leaves the link synchronised.
	a_reply_syncs: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && reply_valid |-> link_state == LINK_SYNC && !seed_valid)
		else $error("reply without the synchronised phase");

	// An issued seed is a table index.
	a_seed_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && seed_valid |-> seed_value < 8'(TABLE_ENTRIES))
		else $error("seed value outside the table");

endmodule

[rtl/hskw_cfg.sv]
`timescale 1ns / 1ps

module hskw_cfg import hskw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Writes to indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte         <= 8'd0;
			cfg_q.ack_byte          <= 8'd0;
			cfg_q.seed_period_ticks <= 16'd1;
			cfg_q.key_window_ticks  <= 16'd1;
			cfg_q.key_error_limit   <= 8'd1;
			cfg_q.timeout_limit     <= 8'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SYNC_BYTE:     cfg_q.sync_byte         <= cfg_data[7:0];
				CFG_ACK_BYTE:      cfg_q.ack_byte          <= cfg_data[7:0];
				CFG_SEED_PERIOD:   cfg_q.seed_period_ticks <= cfg_data;
				CFG_KEY_WINDOW:    cfg_q.key_window_ticks  <= cfg_data;
				CFG_KEY_ERR_LIMIT: cfg_q.key_error_limit   <= cfg_data[7:0];
				CFG_TIMEOUT_LIMIT: cfg_q.timeout_limit     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/hskw_core.sv]
`timescale 1ns / 1ps

module hskw_core import hskw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] kind,
	input  logic [7:0] data,
	input  cfg_t       cfg,
	output res_t       res
);

	link_phase_t phase_q,      phase_d;
	logic [15:0] period_q,     period_d;
	idx_t        idx_q,        idx_d;
	idx_t        last_q,       last_d;
	logic        last_v_q,     last_v_d;
	logic        awaiting_q,   awaiting_d;
	logic [15:0] window_q,     window_d;
	logic [7:0]  wrong_tot_q,  wrong_tot_d;
	logic [7:0]  late_tot_q,   late_tot_d;
	logic [7:0]  wrong_run_q,  wrong_run_d;
	logic [7:0]  late_run_q,   late_run_d;
	status_t     status_q,     status_d;
	logic [15:0] seed_cnt_q,   seed_cnt_d;
	logic [15:0] key_cnt_q,    key_cnt_d;

	logic        reply;
	logic        seed_v;
	logic [IDX_W:0] idx_inc;

	assign idx_inc = {1'b0, idx_q} + (IDX_W+1)'(1);

	always_comb begin
		phase_d     = phase_q;
		period_d    = period_q;
		idx_d       = idx_q;
		last_d      = last_q;
		last_v_d    = last_v_q;
		awaiting_d  = awaiting_q;
		window_d    = window_q;
		wrong_tot_d = wrong_tot_q;
		late_tot_d  = late_tot_q;
		wrong_run_d = wrong_run_q;
		late_run_d  = late_run_q;
		status_d    = status_q;
		seed_cnt_d  = seed_cnt_q;
		key_cnt_d   = key_cnt_q;
		reply       = 1'b0;
		seed_v      = 1'b0;

		case (kind_t'(kind))
			KIND_TICK: begin
				if (phase_q == LINK_EST) begin
					period_d = period_q + 16'd1;
					if (period_d >= cfg.seed_period_ticks) begin
						period_d = 16'd0;
						if (!last_v_q || last_q != idx_q) begin
							window_d   = 16'd0;
							awaiting_d = 1'b1;
							last_d     = idx_q;
							last_v_d   = 1'b1;
							seed_cnt_d = seed_cnt_q + 16'd1;
							seed_v     = 1'b1;
						end
					end
					// A freshly opened window already counts this tick.
					if (awaiting_d) begin
						window_d = window_d + 16'd1;
						if (window_d >= cfg.key_window_ticks) begin
							window_d = 16'd0;
							if (late_tot_q != 8'hFF)
								late_tot_d = late_tot_q + 8'd1;
							late_run_d = sat_run(late_run_q, cfg.timeout_limit);
						end
					end else begin
						window_d = 16'd0;
					end
					if (status_q != ST_LATCHED) begin
						status_d = ST_NORMAL;
						if (wrong_run_d != 8'd0)
							status_d = ST_KEY_ERR;
						if (late_run_d != 8'd0)
							status_d = ST_TIMEOUT;
						if (wrong_run_d >= cfg.key_error_limit ||
						    late_run_d >= cfg.timeout_limit)
							status_d = ST_LATCHED;
					end
				end
			end
			KIND_KEY: begin
				key_cnt_d  = key_cnt_q + 16'd1;
				awaiting_d = 1'b0;
				late_run_d = 8'd0;
				if (data == key_of(idx_q)) begin
					wrong_run_d = 8'd0;
				end else begin
					if (wrong_tot_q != 8'hFF)
						wrong_tot_d = wrong_tot_q + 8'd1;
					wrong_run_d = sat_run(wrong_run_q, cfg.key_error_limit);
				end
				if (idx_inc >= (IDX_W+1)'(TABLE_ENTRIES))
					idx_d = '0;
				else
					idx_d = idx_inc[IDX_W-1:0];
			end
			KIND_HANDSHAKE: begin
				if (data == cfg.sync_byte) begin
					phase_d = LINK_SYNC;
					reply   = 1'b1;
				end else if (phase_q == LINK_SYNC) begin
					phase_d = (data == cfg.ack_byte + 8'd1) ? LINK_EST : LINK_NONE;
				end
			end
			default: ;
		endcase

		res.link_state      = phase_d;
		res.error_status    = status_d;
		res.reply_valid     = reply;
		res.seed_valid      = seed_v;
		res.seed_value      = seed_v ? 8'(idx_q) : 8'd0;
		res.key_error_total = wrong_tot_d;
		res.timeout_total   = late_tot_d;
		res.seeds_sent      = seed_cnt_d;
		res.keys_received   = key_cnt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= LINK_NONE;
			period_q    <= 16'd0;
			idx_q       <= '0;
			last_q      <= '0;
			last_v_q    <= 1'b0;
			awaiting_q  <= 1'b0;
			window_q    <= 16'd0;
			wrong_tot_q <= 8'd0;
			late_tot_q  <= 8'd0;
			wrong_run_q <= 8'd0;
			late_run_q  <= 8'd0;
			status_q    <= ST_NORMAL;
			seed_cnt_q  <= 16'd0;
			key_cnt_q   <= 16'd0;
		end else if (step) begin
			phase_q     <= phase_d;
			period_q    <= period_d;
			idx_q       <= idx_d;
			last_q      <= last_d;
			last_v_q    <= last_v_d;
			awaiting_q  <= awaiting_d;
			window_q    <= window_d;
			wrong_tot_q <= wrong_tot_d;
			late_tot_q  <= late_tot_d;
			wrong_run_q <= wrong_run_d;
			late_run_q  <= late_run_d;
			status_q    <= status_d;
			seed_cnt_q  <= seed_cnt_d;
			key_cnt_q   <= key_cnt_d;
		end
	end

endmodule
